[sv/fa_pkg.sv]
// shared constants and codes for the frame allocator
`default_nettype none

package fa_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned FRAME_NUM_W = 19;
  localparam int unsigned FIU_W       = 11;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  // map word geometry
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_IDX_W = 5;

  // parameter defaults
  localparam int unsigned DEF_MAX_FRAMES = 1024;
  localparam int unsigned DEF_PAGE_SHIFT = 13;

  // frames managed after reset
  localparam logic [FIU_W-1:0] FIU_RESET = 11'd1024;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INIT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BREAK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES       = 3'd4;

  // sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_INIT     = 8'b0000_0100,
    ST_ALLOC    = 8'b0000_1000,
    ST_REL_CALC = 8'b0001_0000,
    ST_REL_RD   = 8'b0010_0000,
    ST_REL_WR   = 8'b0100_0000,
    ST_RESP     = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

[sv/frame_allocator_first_free.sv]
// bitmap page frame allocator, lowest free frame first
//
// One free bit per physical page frame is kept in a single map ram of 32-bit
// words (ceil(MAX_FRAMES/32) words, registered read data). Frame i starts
// at byte address memory_base_address + i * 2^PAGE_SHIFT (modulo 2^32) and
// its frame number is that address shifted right by PAGE_SHIFT. One request
// is worked on at a time, and every request gives exactly one result.
// Initialize walks all frames one per cycle with a running address and three
// address compares, packing 32 frames into a word before writing it back.
// Allocate streams map words out of the ram one per cycle and stops at the
// first word with a free frame below the frame count. Release works out the
// frame index by subtracting the base frame number and then does one
// read-modify-write. The next request is taken while a result still waits
// in the result register. After reset a clearing pass writes zero to every
// map word with in_ready_o low; register writes are taken at any time and
// are meant to happen only while idle.
// A frame count above MAX_FRAMES is clipped; zero makes every allocate fail.
`default_nettype none

module frame_allocator_first_free
  import fa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // register write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ADDR_W-1:0]      cfg_data_i,
  // request channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [KIND_W-1:0]      kind_i,
  input  wire logic [FRAME_NUM_W-1:0] release_frame_i,
  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        status_o,
  output logic [FRAME_NUM_W-1:0]      frame_number_o
);

  // map geometry
  localparam int unsigned NWORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned FW     = AW + WORD_IDX_W;   // frame index width
  localparam int unsigned CNT_W  = FW + 1;            // frame count width
  localparam logic [AW-1:0]         LAST_WORD  = AW'(NWORDS - 1);
  localparam logic [WORD_IDX_W-1:0] LAST_BIT   = WORD_IDX_W'(WORD_W - 1);
  localparam logic [ADDR_W-1:0]     PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;
  // frame numbers live in the upper address bits only
  localparam logic [ADDR_W-1:0]     FN_MASK    = {ADDR_W{1'b1}} >> PAGE_SHIFT;

  // configuration registers
  logic [ADDR_W-1:0] mem_base_q, kbrk_q, stk_start_q, stk_end_q;
  logic [FIU_W-1:0]  fiu_q;

  // sequencer and counters
  state_e                state_q, state_d;
  logic [AW-1:0]         wptr_q, wptr_d;         // clear and init word pointer
  logic [WORD_IDX_W-1:0] bptr_q, bptr_d;         // init bit pointer
  logic [AW-1:0]         rptr_q, rptr_d;         // allocate read pointer
  logic                  rd_done_q, rd_done_d;
  logic                  chk_valid_q, chk_valid_d;
  logic [AW-1:0]         chk_ptr_q, chk_ptr_d;   // word now on the read data

  // working payload
  logic [WORD_W-1:0]      word_q, word_d;        // init word being packed
  logic [ADDR_W-1:0]      addr_q, addr_d;        // init frame start address
  logic [FRAME_NUM_W-1:0] rel_q, rel_d;
  logic [FW-1:0]          rel_idx_q, rel_idx_d;
  logic                   res_ok_q, res_ok_d;     // allocate found a frame
  logic                   res_status_q, res_status_d;
  logic [FW-1:0]          res_idx_q, res_idx_d;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic                   out_status_q, out_status_d;
  logic [FRAME_NUM_W-1:0] out_frame_q, out_frame_d;

  // map ram port
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  // datapath helpers
  logic [ADDR_W-1:0]     cnt_full;
  logic [CNT_W-1:0]      n_cnt;
  logic [ADDR_W-1:0]     base_fn;
  logic                  in_acc, out_load;
  logic                  init_used, init_in_range, init_bit;
  logic [WORD_W-1:0]     init_word;
  logic [AW:0]           n_words;
  logic [WORD_W-1:0]     alloc_mask, alloc_hits;
  logic [WORD_IDX_W-1:0] alloc_pos;
  logic [ADDR_W-1:0]     rel_full, rel_off, res_fn;
  logic                  rel_hit;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_acc         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign frame_number_o = out_frame_q;

  // frames managed, clipped to the map size
  assign cnt_full = ({{(ADDR_W-FIU_W){1'b0}}, fiu_q} > ADDR_W'(MAX_FRAMES)) ?
                    ADDR_W'(MAX_FRAMES) : {{(ADDR_W-FIU_W){1'b0}}, fiu_q};
  assign n_cnt    = cnt_full[CNT_W-1:0];
  // frame number of frame 0; no carry reaches it from the page offset
  assign base_fn  = mem_base_q >> PAGE_SHIFT;

  // initialize: one frame per cycle against break and stack window
  assign init_used     = (addr_q < kbrk_q) ||
                         ((addr_q >= stk_start_q) && (addr_q < stk_end_q));
  assign init_in_range = ({1'b0, wptr_q, bptr_q} < n_cnt);
  assign init_bit      = init_in_range && !init_used;

  always_comb begin
    init_word          = word_q;
    init_word[bptr_q]  = init_bit;
  end

  // allocate: only frames below the count are candidates
  assign n_words = n_cnt[CNT_W-1:WORD_IDX_W];

  always_comb begin
    if (n_words > {1'b0, chk_ptr_q}) begin
      alloc_mask = '1;
    end else if (n_words == {1'b0, chk_ptr_q}) begin
      alloc_mask = (WORD_W'(1) << n_cnt[WORD_IDX_W-1:0]) - WORD_W'(1);
    end else begin
      alloc_mask = '0;
    end
  end

  assign alloc_hits = mem_rdata & alloc_mask;

  // lowest set bit
  always_comb begin
    alloc_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (alloc_hits[b]) begin
        alloc_pos = WORD_IDX_W'(b);
      end
    end
  end

  // release: index = frame number minus base frame number, in frame-number width
  assign rel_full = {{(ADDR_W-FRAME_NUM_W){1'b0}}, rel_q};
  assign rel_off  = (rel_full - base_fn) & FN_MASK;
  assign rel_hit  = ((rel_full & ~FN_MASK) == '0) &&
                    (rel_off < {{(ADDR_W-CNT_W){1'b0}}, n_cnt});

  // allocated frame number, low bits only
  assign res_fn   = (base_fn + {{(ADDR_W-FW){1'b0}}, res_idx_q}) & FN_MASK;

  // the result register takes a new result when empty or being drained
  assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    wptr_d       = wptr_q;
    bptr_d       = bptr_q;
    rptr_d       = rptr_q;
    rd_done_d    = rd_done_q;
    chk_valid_d  = 1'b0;
    chk_ptr_d    = rptr_q;
    word_d       = word_q;
    addr_d       = addr_q;
    rel_d        = rel_q;
    rel_idx_d    = rel_idx_q;
    res_ok_d     = res_ok_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = wptr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = rptr_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = wptr_q;
        wptr_d    = wptr_q + AW'(1);
        if (wptr_q == LAST_WORD) begin
          wptr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_ok_d     = 1'b0;
          res_status_d = 1'b0;
          rel_d        = release_frame_i;
          unique case (kind_i)
            KIND_INIT: begin
              wptr_d  = '0;
              bptr_d  = '0;
              word_d  = '0;
              addr_d  = mem_base_q;
              state_d = ST_INIT;
            end
            KIND_ALLOC: begin
              rptr_d    = '0;
              rd_done_d = 1'b0;
              state_d   = ST_ALLOC;
            end
            KIND_RELEASE: begin
              state_d = ST_REL_CALC;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_INIT: begin
        addr_d = addr_q + PAGE_BYTES;
        bptr_d = bptr_q + WORD_IDX_W'(1);
        word_d = init_word;
        if (bptr_q == LAST_BIT) begin
          mem_we    = 1'b1;
          mem_waddr = wptr_q;
          mem_wdata = init_word;
          word_d    = '0;
          wptr_d    = wptr_q + AW'(1);
          if (wptr_q == LAST_WORD) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_ALLOC: begin
        // stream word reads, check the word read last cycle
        mem_re      = !rd_done_q;
        mem_raddr   = rptr_q;
        chk_valid_d = !rd_done_q;
        chk_ptr_d   = rptr_q;
        if (!rd_done_q) begin
          rptr_d = rptr_q + AW'(1);
          if (rptr_q == LAST_WORD) begin
            rd_done_d = 1'b1;
          end
        end
        if (chk_valid_q) begin
          if (alloc_hits != '0) begin
            mem_we    = 1'b1;
            mem_waddr = chk_ptr_q;
            mem_wdata = mem_rdata & ~(WORD_W'(1) << alloc_pos);
            res_ok_d  = 1'b1;
            res_idx_d = {chk_ptr_q, alloc_pos};
            state_d   = ST_RESP;
          end else if (chk_ptr_q == LAST_WORD) begin
            res_status_d = 1'b1;
            state_d      = ST_RESP;
          end
        end
      end
      ST_REL_CALC: begin
        rel_idx_d = rel_off[FW-1:0];
        state_d   = rel_hit ? ST_REL_RD : ST_RESP;
      end
      ST_REL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rel_idx_q[FW-1:WORD_IDX_W];
        state_d   = ST_REL_WR;
      end
      ST_REL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rel_idx_q[FW-1:WORD_IDX_W];
        mem_wdata = mem_rdata | (WORD_W'(1) << rel_idx_q[WORD_IDX_W-1:0]);
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_frame_d  = out_frame_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_frame_d  = res_ok_q ? res_fn[FRAME_NUM_W-1:0] : '0;
    end
  end

  // control state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wptr_q      <= '0;
      bptr_q      <= '0;
      rptr_q      <= '0;
      rd_done_q   <= 1'b0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      mem_base_q  <= '0;
      kbrk_q      <= '0;
      stk_start_q <= '0;
      stk_end_q   <= '0;
      fiu_q       <= FIU_RESET;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      bptr_q      <= bptr_d;
      rptr_q      <= rptr_d;
      rd_done_q   <= rd_done_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_MEM_BASE:     mem_base_q  <= cfg_data_i;
          REG_KERNEL_BREAK: kbrk_q      <= cfg_data_i;
          REG_STACK_START:  stk_start_q <= cfg_data_i;
          REG_STACK_END:    stk_end_q   <= cfg_data_i;
          REG_FRAMES:       fiu_q       <= cfg_data_i[FIU_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_ptr_q    <= chk_ptr_d;
    word_q       <= word_d;
    addr_q       <= addr_d;
    rel_q        <= rel_d;
    rel_idx_q    <= rel_idx_d;
    res_ok_q     <= res_ok_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    out_status_q <= out_status_d;
    out_frame_q  <= out_frame_d;
  end

  fa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // no map write while waiting for a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("map written while idle");

  // the word under check was read from inside the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_valid_q |-> (chk_ptr_q <= LAST_WORD))
    else $error("allocate checked a word past the map");

  // an accepted request always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("request accepted without work");

  // a failed allocate reports frame zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (frame_number_o == '0))
    else $error("failed allocate with nonzero frame");

  // a result waits while the result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RESP) && out_valid_q && !out_ready_i) |=> (state_q == ST_RESP))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

[sv/fa_ram.sv]
// generic single-write single-read ram with registered read data
`default_nettype none

module fa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[tb/frame_allocator_first_free_tb.sv]
// testbench for the first-free page frame allocator with a self-checking predictor
module frame_allocator_first_free_tb
  import fa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // block geometry at its default parameters
  localparam int unsigned MAXF   = DEF_MAX_FRAMES;
  localparam int unsigned PSHIFT = DEF_PAGE_SHIFT;

  // request kind that the block treats as a no-op
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // cycles with no handshake on any channel before the run is called hung;
  // the limit lies well above an initialize, which walks every frame, and the long hold
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE_TAIL  = 40;
  localparam int unsigned PRINT_CAP    = 50;

  typedef struct packed {
    logic                   status;
    logic [FRAME_NUM_W-1:0] frame_number;
  } frame_result_t;

  // dut signals, known from time zero
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [ADDR_W-1:0]      cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic [KIND_W-1:0]      kind_i          = '0;
  logic [FRAME_NUM_W-1:0] release_frame_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic                   status_o;
  logic [FRAME_NUM_W-1:0] frame_number_o;

  // predictor copy of the registers and the free map
  logic [ADDR_W-1:0] base_addr = '0;
  logic [ADDR_W-1:0] brk_addr  = '0;
  logic [ADDR_W-1:0] stk_start = '0;
  logic [ADDR_W-1:0] stk_end   = '0;
  logic [FIU_W-1:0]  frame_cnt = FIU_RESET;
  bit                free_bits [MAXF];

  // results still owed by the block, oldest first
  frame_result_t          pending_results [$];
  // frame numbers handed out and not yet given back, used to build releases
  logic [FRAME_NUM_W-1:0] granted_frames [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          no_idle        = 1'b0;  // set for the final stretch: no gaps, no stalls
  bit          hold_req       = 1'b0;  // asks the result side for one long hold-off
  bit          holding        = 1'b0;  // result side is inside that hold-off
  frame_result_t due;

  frame_allocator_first_free u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .release_frame_i (release_frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_number_o  (frame_number_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // frame count as the block uses it: clipped to the map size
  function automatic int unsigned managed_frames();
    return (frame_cnt > MAXF) ? MAXF : int'(frame_cnt);
  endfunction

  // start byte address of frame idx, wrapping modulo 2^32
  function automatic logic [ADDR_W-1:0] frame_start(input int unsigned idx);
    logic [ADDR_W-1:0] off;
    off = ADDR_W'(idx) << PSHIFT;
    return base_addr + off;
  endfunction

  // applies one request to the predicted map and returns the result it gives
  function automatic frame_result_t allocator_outcome(input logic [KIND_W-1:0]      kind,
                                                      input logic [FRAME_NUM_W-1:0] rel);
    frame_result_t     res;
    int unsigned       n;
    int unsigned       i;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] fnum;
    bit                found;
    res   = '0;
    n     = managed_frames();
    found = 1'b0;
    case (kind)
      KIND_INIT: begin
        // frames past the count come out used
        for (i = 0; i < MAXF; i++) begin
          a = frame_start(i);
          free_bits[i] = (i < n) && !(a < brk_addr || (stk_start <= a && a < stk_end));
        end
      end
      KIND_ALLOC: begin
        res.status = 1'b1;
        for (i = 0; i < n && !found; i++) begin
          if (free_bits[i]) begin
            free_bits[i]     = 1'b0;
            fnum             = frame_start(i) >> PSHIFT;
            res.frame_number = fnum[FRAME_NUM_W-1:0];
            res.status       = 1'b0;
            found            = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        // full shifted address against the number; unknown numbers do nothing
        for (i = 0; i < n && !found; i++) begin
          fnum = frame_start(i) >> PSHIFT;
          if (fnum == ADDR_W'(rel)) begin
            free_bits[i] = 1'b1;
            found        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request, register and result-side drivers
  // ---------------------------------------------------------------------------

  // offers one request, optionally after a random gap, and books its result
  task automatic issue_request(input logic [KIND_W-1:0]      kind,
                               input logic [FRAME_NUM_W-1:0] rel);
    frame_result_t res;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    release_frame_i <= rel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // accepted at this edge
    res = allocator_outcome(kind, rel);
    pending_results.push_back(res);
    if (kind == KIND_INIT) begin
      granted_frames.delete();
    end else if (kind == KIND_ALLOC && res.status == 1'b0) begin
      granted_frames.push_back(res.frame_number);
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // one register write; valid stays up so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_MEM_BASE:     base_addr = val;
      REG_KERNEL_BREAK: brk_addr  = val;
      REG_STACK_START:  stk_start = val;
      REG_STACK_END:    stk_end   = val;
      REG_FRAMES:       frame_cnt = val[FIU_W-1:0];
      default: begin
      end
    endcase
  endtask

  // writes all five registers; only called with nothing in flight
  task automatic set_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] brk,
                            input logic [ADDR_W-1:0] ss, input logic [ADDR_W-1:0] se,
                            input logic [FIU_W-1:0] cnt);
    write_reg(REG_MEM_BASE, base);
    write_reg(REG_KERNEL_BREAK, brk);
    write_reg(REG_STACK_START, ss);
    write_reg(REG_STACK_END, se);
    write_reg(REG_FRAMES, ADDR_W'(cnt));
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small maps with the break and the stack window placed on frames
  task automatic random_config();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] brk;
    logic [ADDR_W-1:0] ss;
    logic [ADDR_W-1:0] se;
    logic [FIU_W-1:0]  cnt;
    int unsigned       sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      cnt = FIU_W'($urandom_range(1, 64));
    end else if (sel < 9) begin
      cnt = FIU_W'($urandom_range(65, MAXF));
    end else begin
      cnt = FIU_W'($urandom_range(MAXF + 1, 2047));
    end
    base = $urandom;
    if ($urandom_range(0, 3) != 0) base[PSHIFT-1:0] = '0;
    if ($urandom_range(0, 4) == 0) begin
      brk = $urandom;
    end else begin
      brk = base + (ADDR_W'($urandom_range(0, cnt)) << PSHIFT);
    end
    if ($urandom_range(0, 4) == 0) begin
      ss = $urandom;
      se = $urandom;
    end else begin
      ss = base + (ADDR_W'($urandom_range(0, cnt)) << PSHIFT);
      se = ss + (ADDR_W'($urandom_range(0, 16)) << PSHIFT);
    end
    set_config(base, brk, ss, se, cnt);
  endtask

  // one random request: mostly allocations and give-backs of granted frames,
  // the rest stray releases, re-initializations and the unused kind
  task automatic random_request();
    int unsigned            pick;
    int unsigned            slot;
    logic [ADDR_W-1:0]      first_fnum;
    logic [FRAME_NUM_W-1:0] rel;
    pick = $urandom_range(0, 99);
    rel  = FRAME_NUM_W'($urandom);
    if (pick < 48) begin
      issue_request(KIND_ALLOC, rel);
    end else if (pick < 78 && granted_frames.size() != 0) begin
      slot = $urandom_range(0, granted_frames.size() - 1);
      rel  = granted_frames[slot];
      granted_frames.delete(slot);
      issue_request(KIND_RELEASE, rel);
    end else if (pick < 88) begin
      issue_request(KIND_RELEASE, rel);
    end else if (pick < 93) begin
      // near the managed range, a few past its end
      first_fnum = base_addr >> PSHIFT;
      rel = FRAME_NUM_W'(first_fnum + $urandom_range(0, frame_cnt + 3));
      issue_request(KIND_RELEASE, rel);
    end else if (pick < 97) begin
      issue_request(KIND_INIT, rel);
    end else begin
      issue_request(KIND_UNUSED, rel);
    end
  endtask

  // result side: random stall bursts, ready stretches, and one long hold on demand
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        holding     = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        holding  = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  // one line per mismatch; the count keeps going past the print cap
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH %s: got 0x%0h, predicted 0x%0h, at %0t", what, got, want, $time);
    end
    mismatch_count++;
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", frame_number_o, 0);
      end else begin
        due = pending_results.pop_front();
        if (status_o !== due.status) begin
          report_mismatch("status", status_o, due.status);
        end
        if (frame_number_o !== due.frame_number) begin
          report_mismatch("frame_number", frame_number_o, due.frame_number);
        end
      end
    end
  end

  // hang detector: any handshake on any channel resets the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset map is all used: allocate fails until something is released;
  // also the top release number, the last and first frame, the unused kind
  task automatic test_empty_map();
    issue_request(KIND_ALLOC, '0);
    issue_request(KIND_RELEASE, '1);
    issue_request(KIND_RELEASE, FRAME_NUM_W'(MAXF - 1));
    issue_request(KIND_RELEASE, '0);
    issue_request(KIND_ALLOC, '1);
    issue_request(KIND_ALLOC, '0);
    issue_request(KIND_ALLOC, '0);
    issue_request(KIND_UNUSED, 19'h2AAAA);
    drain_results();
  endtask

  // kernel break and stack window carve used frames out of a small map;
  // double release and release of a kernel frame
  task automatic test_layout();
    logic [ADDR_W-1:0] base;
    base = 32'h8000_0000;
    set_config(base, base + (32'd4 << PSHIFT), base + (32'd8 << PSHIFT),
               base + (32'd10 << PSHIFT), 11'd12);
    issue_request(KIND_INIT, '0);
    issue_request(KIND_ALLOC, '0);
    issue_request(KIND_ALLOC, '0);
    issue_request(KIND_RELEASE, 19'h40005);
    issue_request(KIND_RELEASE, 19'h40005);
    issue_request(KIND_RELEASE, 19'h40000);
    issue_request(KIND_ALLOC, '0);
    drain_results();
  endtask

  // frame addresses run past 2^32 and wrap into a stack window at zero
  task automatic test_address_wrap();
    set_config(32'hFFFF_C000, '0, '0, 32'h0000_4000, 11'd8);
    issue_request(KIND_INIT, '0);
    repeat (4) issue_request(KIND_ALLOC, '0);
    issue_request(KIND_RELEASE, 19'h7FFFE);
    issue_request(KIND_ALLOC, '0);
    drain_results();
  endtask

  // zero frames managed, then an over-range count with every address at its top
  task automatic test_frame_count_edges();
    set_config('0, '0, '0, '0, '0);
    issue_request(KIND_INIT, '0);
    issue_request(KIND_ALLOC, '0);
    drain_results();
    set_config('1, '1, '1, '1, '1);
    issue_request(KIND_INIT, '1);
    issue_request(KIND_ALLOC, '1);
    issue_request(KIND_RELEASE, '1);
    issue_request(KIND_ALLOC, '1);
    drain_results();
  endtask

  // result side holds off for a long stretch while requests keep coming, so
  // the block fills and stalls its input; then a full pause until all are back
  task automatic test_backpressure();
    int unsigned k;
    set_config('0, '0, '0, '0, 11'd64);
    issue_request(KIND_INIT, '0);
    drain_results();
    hold_req = 1'b1;
    while (!holding) @(posedge clk_i);
    for (k = 0; k < 16; k++) begin
      if (k % 4 == 3) begin
        issue_request(KIND_RELEASE, FRAME_NUM_W'(k - 3));
      end else begin
        issue_request(KIND_ALLOC, '0);
      end
    end
    drain_results();
  endtask

  // random phases, each with its own settings and a fresh map; the first two
  // are the all-free reset layout and a map that wraps around the address space
  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 12; phase++) begin
      drain_results();
      if (phase == 0) begin
        set_config('0, '0, '0, '0, FIU_RESET);
      end else if (phase == 1) begin
        set_config(32'hFFFF_E000, '0, '1, '1, FIU_RESET);
      end else begin
        random_config();
      end
      issue_request(KIND_INIT, FRAME_NUM_W'($urandom));
      repeat (50) random_request();
    end
    drain_results();
  endtask

  // last stretch at full rate: no gaps, no stalls
  task automatic test_quiet_tail();
    no_idle = 1'b1;
    random_config();
    issue_request(KIND_INIT, '0);
    repeat (60) random_request();
  endtask

  // reset once, run the tests in turn, then wait out the block and report
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_map();
    test_layout();
    test_address_wrap();
    test_frame_count_edges();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();
    drain_results();
    repeat (SETTLE_TAIL) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
